/* src/cldf_pkg.sv */
// ----------------------------------------------------------------------------
// cldf_pkg: shared types and functions for the CRC-checked line deframer
// Line terminators, CRC-16 constants, status codes, result layout and the
// byte-wide CRC and hex-decode functions.
// ----------------------------------------------------------------------------
package cldf_pkg;

  localparam int unsigned MaxLineDefault = 512;
  localparam int unsigned CountW         = 10;
  localparam int unsigned CrcW           = 16;
  localparam int unsigned TailDepth      = 4;
  localparam int unsigned OutDataW       = 48;

  localparam logic [7:0]      ChCr    = 8'd13;
  localparam logic [7:0]      ChLf    = 8'd10;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } line_status_t;

  // First field in the lowest bits: declare from the top down.
  typedef struct packed {
    logic [CountW-1:0] payload_length;
    logic [CrcW-1:0]   received_check;
    logic [CrcW-1:0]   computed_check;
    line_status_t      line_status;
  } line_result_t;

  // Run one byte through the reflected CRC-16, eight bit steps.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Upper-case hex digit to nibble; bit 4 flags a character that is no digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      v = {1'b0, ch[3:0]};
    end else if (ch >= 8'd65 && ch <= 8'd70) begin
      v = {1'b0, ch[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

/* src/crc_checked_line_deframer_core.sv */
// ----------------------------------------------------------------------------
// crc_checked_line_deframer_core: CR/LF line deframer with CRC-16 check
// Collects serial bytes into lines, runs the payload through CRC-16 on the
// fly and reports match, mismatch or too-short for each non-empty line.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while the skid entry is free; the CRC
//   byte step is one pass of unrolled logic between the line state and its next value.
// Result path: the result of a line is registered into the output register,
//   or into the skid entry while the output register holds an untaken result.
// Reset: rst_n synchronous, active low; clears the line state (CRC 0xFFFF,
//   empty tail, count zero) and empties the two-entry result buffer.
module crc_checked_line_deframer_core #(
  parameter int unsigned MAX_LINE = cldf_pkg::MaxLineDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] line_status, [17:2] computed_check, [33:18] received_check,
  // [43:34] payload_length, [47:44] zero
  output logic [cldf_pkg::OutDataW-1:0] out_tdata
);
  import cldf_pkg::*;

  localparam int unsigned ResW = $bits(line_result_t);

  // --------------------------------------------------------------------------
  // Line state: running CRC, four newest characters (oldest first), count
  // --------------------------------------------------------------------------
  logic [CrcW-1:0]   crc_r,   crc_nxt;
  logic [7:0]        tail_r   [TailDepth];
  logic [7:0]        tail_nxt [TailDepth];
  logic [CountW-1:0] cnt_r,   cnt_nxt;

  // Result buffer: output register plus one skid entry
  line_result_t out_r,  out_nxt;
  line_result_t skid_r, skid_nxt;
  logic         out_valid_r,  out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;

  logic         in_fire, out_fire, is_term, push;
  line_result_t res;
  logic [4:0]   hex [TailDepth];
  logic         hex_ok;
  logic [CrcW-1:0]   rx_check;
  logic [CountW-1:0] cnt_inc;

  // Accept while the skid entry is free; a result then always has a place.
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign is_term   = (in_tdata == ChCr) || (in_tdata == ChLf);
  assign push      = in_fire && is_term && (cnt_r != '0);
  assign cnt_inc   = cnt_r + CountW'(1);

  // Decode the check field from the tail, first character in the top nibble.
  always_comb begin
    hex_ok = 1'b1;
    for (int i = 0; i < TailDepth; i++) begin
      hex[i] = hex_value(tail_r[i]);
      if (hex[i][4]) begin
        hex_ok = 1'b0;
      end
    end
    rx_check = hex_ok ? {hex[0][3:0], hex[1][3:0], hex[2][3:0], hex[3][3:0]}
                      : '0;
  end

  // Build the line result; a too-short line reports zeros.
  always_comb begin
    res = '0;
    if (cnt_r < CountW'(TailDepth)) begin
      res.line_status = ST_SHORT;
    end else begin
      res.computed_check = crc_r;
      res.received_check = rx_check;
      res.payload_length = cnt_r - CountW'(TailDepth);
      res.line_status    = (hex_ok && (rx_check == crc_r)) ? ST_MATCH : ST_MISMATCH;
    end
  end

  // Advance the line state on each accepted word.
  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < TailDepth; i++) begin
      tail_nxt[i] = tail_r[i];
    end
    if (in_fire) begin
      if (is_term) begin
        // End of line: restart, whether or not a result went out.
        crc_nxt = CrcInit;
        cnt_nxt = '0;
        for (int i = 0; i < TailDepth; i++) begin
          tail_nxt[i] = '0;
        end
      end else if (cnt_r >= CountW'(MAX_LINE)) begin
        // Over-long line: drop it.
        crc_nxt = CrcInit;
        cnt_nxt = '0;
        for (int i = 0; i < TailDepth; i++) begin
          tail_nxt[i] = '0;
        end
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_r >= CountW'(TailDepth)) begin
          // Oldest character leaves the tail into the CRC.
          crc_nxt = crc_byte(crc_r, tail_r[0]);
          for (int i = 0; i < TailDepth - 1; i++) begin
            tail_nxt[i] = tail_r[i+1];
          end
          tail_nxt[TailDepth-1] = in_tdata;
        end else begin
          tail_nxt[cnt_r[$clog2(TailDepth)-1:0]] = in_tdata;
        end
      end
    end
  end

  // Result buffer: a push finds the skid entry empty (in_tready gates it).
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (push) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_nxt        = skid_r;
      out_valid_nxt  = skid_valid_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= CrcInit;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < TailDepth; i++) begin
        tail_r[i] <= '0;
      end
    end else begin
      crc_r        <= crc_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      for (int i = 0; i < TailDepth; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - ResW)'(0), out_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CountW'(MAX_LINE))
    else $error("line count beyond the line limit");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.line_status == ST_SHORT) |->
      (out_r.computed_check == '0 && out_r.received_check == '0 &&
       out_r.payload_length == '0))
    else $error("too-short result carries nonzero fields");

  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_term) |=> (cnt_r == '0 && crc_r == CrcInit))
    else $error("line state not restarted after a terminator");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CRC-checked line deframer core
// Drives a short table of byte words, then an over-long line, then random
// lines (good, wrong check, bad hex, short, noise) with random idling on
// both channels, and checks every result against a line predictor or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cldf_pkg::*;

  localparam int unsigned MaxLine     = MaxLineDefault;
  localparam int          RandomWords = 350;
  localparam int          IdleLimit   = 2000;
  localparam int          DrainCycles = 16;
  localparam int          DirRows     = 26;

  // One byte word of stimulus; typed rows carry a hand-written expectation.
  typedef struct packed {
    logic [7:0]   data;
    logic         typed;
    line_result_t want;
  } stim_row_t;

  typedef enum int {
    KindGood,
    KindWrongCheck,
    KindBadHex,
    KindShort,
    KindNoise
  } line_kind_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = 8'h00;   // [7:0] rx_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [1:0] line_status, [17:2] computed_check, [33:18] received_check,
  // [43:34] payload_length, [47:44] zero
  logic [OutDataW-1:0] out_tdata;

  // Predictor copy of the line state.
  logic [CrcW-1:0] line_crc;
  logic [7:0]      tail_chars [TailDepth];
  int unsigned     char_count;

  stim_row_t    byte_words [$];
  stim_row_t    dir_table [DirRows];
  stim_row_t    cur_word;
  line_result_t line_results_q [$];

  int unsigned words_taken    = 0;
  int unsigned quiet_from     = 0;
  int unsigned lines_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned in_gap         = 0;
  int unsigned out_stall      = 0;
  int unsigned idle_cycles    = 0;

  crc_checked_line_deframer_core #(
    .MAX_LINE(MaxLine)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line predictor
  // --------------------------------------------------------------------------

  // Reflected CRC-16 step over one byte, LSB first.
  function automatic logic [CrcW-1:0] crc16_step(input logic [CrcW-1:0] acc,
                                                 input logic [7:0] b);
    logic [CrcW-1:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  // Upper-case hex character to nibble; bit 4 set means not a digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
    if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic void clear_line_model();
    line_crc   = CrcInit;
    char_count = 0;
    for (int i = 0; i < TailDepth; i++) tail_chars[i] = 8'h00;
  endfunction

  // Advance the line state by one accepted byte word; return 1 with the
  // line result when the word closes a non-empty line.
  function automatic bit absorb_byte(input logic [7:0] b, output line_result_t res);
    logic [4:0] h;
    bit         hex_ok;
    res = '0;
    if (b == ChCr || b == ChLf) begin
      if (char_count == 0) return 1'b0;
      if (char_count < TailDepth) begin
        res.line_status = ST_SHORT;
      end else begin
        hex_ok = 1'b1;
        for (int i = 0; i < TailDepth; i++) begin
          h = nibble_of(tail_chars[i]);
          if (h[4]) hex_ok = 1'b0;
          res.received_check = {res.received_check[11:0], h[3:0]};
        end
        if (!hex_ok) res.received_check = '0;
        res.computed_check = line_crc;
        res.payload_length = CountW'(char_count - TailDepth);
        res.line_status = (hex_ok && res.received_check == line_crc) ? ST_MATCH
                                                                      : ST_MISMATCH;
      end
      clear_line_model();
      return 1'b1;
    end
    // Oldest tail character leaves into the CRC once the tail is full.
    if (char_count >= TailDepth) begin
      line_crc      = crc16_step(line_crc, tail_chars[0]);
      tail_chars[0] = tail_chars[1];
      tail_chars[1] = tail_chars[2];
      tail_chars[2] = tail_chars[3];
      tail_chars[3] = b;
    end else begin
      tail_chars[char_count] = b;
    end
    char_count++;
    // Drop an over-long line and start over.
    if (char_count > MaxLine) clear_line_model();
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  function automatic stim_row_t word_row(input logic [7:0] b, input bit typed,
                                         input line_status_t st,
                                         input logic [CrcW-1:0] comp,
                                         input logic [CrcW-1:0] recv,
                                         input logic [CountW-1:0] plen);
    stim_row_t r;
    r                     = '0;
    r.data                = b;
    r.typed               = typed;
    r.want.line_status    = st;
    r.want.computed_check = comp;
    r.want.received_check = recv;
    r.want.payload_length = plen;
    return r;
  endfunction

  function automatic stim_row_t plain(input logic [7:0] b);
    return word_row(b, 1'b0, ST_MATCH, '0, '0, '0);
  endfunction

  // Any byte but a line terminator.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'(($urandom_range(0, 255)));
    while (b == ChCr || b == ChLf) b = 8'(($urandom_range(0, 255)));
    return b;
  endfunction

  // A character that breaks the check field: lower-case hex or non-hex junk.
  function automatic logic [7:0] bad_hex_char();
    logic [7:0] b;
    logic [4:0] nib;
    if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 5));
    b   = text_byte();
    nib = nibble_of(b);
    while (!nib[4]) begin
      b   = text_byte();
      nib = nibble_of(b);
    end
    return b;
  endfunction

  task automatic push_word(input logic [7:0] b);
    byte_words = {byte_words, plain(b)};
  endtask

  task automatic push_terminator();
    push_word(($urandom_range(0, 1) != 0) ? ChCr : ChLf);
    // Now and then follow with an empty line.
    if ($urandom_range(0, 7) == 0) push_word(($urandom_range(0, 1) != 0) ? ChCr : ChLf);
  endtask

  task automatic queue_line(input line_kind_t kind, input int plen);
    logic [CrcW-1:0] crc;
    logic [CrcW-1:0] check;
    logic [7:0]      chars [TailDepth];
    logic [7:0]      b;
    int              n;
    crc = CrcInit;
    case (kind)
      KindShort: begin
        n = $urandom_range(1, 3);
        repeat (n) push_word(text_byte());
        push_terminator();
      end
      KindNoise: begin
        // Raw bytes, terminators included; may leave a partial line behind.
        n = $urandom_range(1, 12);
        repeat (n) begin
          b = 8'(($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0) b = ($urandom_range(0, 1) != 0) ? ChCr : ChLf;
          push_word(b);
        end
      end
      default: begin
        repeat (plen) begin
          b = text_byte();
          crc = crc16_step(crc, b);
          push_word(b);
        end
        check = crc;
        if (kind == KindWrongCheck) check = check ^ (16'h1 << $urandom_range(0, 15));
        for (int i = 0; i < TailDepth; i++) chars[i] = hex_char(check[15 - 4*i -: 4]);
        if (kind == KindBadHex) chars[$urandom_range(0, 3)] = bad_hex_char();
        for (int i = 0; i < TailDepth; i++) push_word(chars[i]);
        push_terminator();
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH line %0d %s: got 0x%0h want 0x%0h", lines_checked, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input channel: present byte words, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    line_result_t predicted;
    bit           produced;
    if (!rst_n) begin
      clear_line_model();
      in_tvalid <= 1'b0;
    end else begin
      // Word taken this edge: advance the predictor and log what it closes.
      if (in_tvalid && in_tready) begin
        produced = absorb_byte(cur_word.data, predicted);
        if (cur_word.typed) begin
          line_results_q = {line_results_q, cur_word.want};
        end else if (produced) begin
          line_results_q = {line_results_q, predicted};
        end
        words_taken++;
      end
      // Hold the word until it is taken; only then idle or load the next.
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_words.size() != 0) begin
          cur_word = byte_words.pop_front();
          in_tdata  <= cur_word.data;
          in_tvalid <= 1'b1;
          if (words_taken < quiet_from && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel: random back-pressure, compare with the oldest line result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink_out
    line_result_t got;
    line_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(line_result_t)-1:0];
        if (line_results_q.size() == 0) begin
          report_mismatch("result with no line pending", 32'(got.computed_check), 32'h0);
        end else begin
          want = line_results_q.pop_front();
          if (got.line_status != want.line_status)
            report_mismatch("line_status", 32'(got.line_status), 32'(want.line_status));
          if (got.computed_check != want.computed_check)
            report_mismatch("computed_check", 32'(got.computed_check),
                            32'(want.computed_check));
          if (got.received_check != want.received_check)
            report_mismatch("received_check", 32'(got.received_check),
                            32'(want.received_check));
          if (got.payload_length != want.payload_length)
            report_mismatch("payload_length", 32'(got.payload_length),
                            32'(want.payload_length));
          if (out_tdata[OutDataW-1:$bits(line_result_t)] != '0)
            report_mismatch("pad bits", 32'(out_tdata[OutDataW-1:$bits(line_result_t)]),
                            32'h0);
        end
        lines_checked++;
      end
      // Stall in random bursts, none in the closing stretch.
      if (out_stall != 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (words_taken < quiet_from && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("crc_checked_line_deframer_core verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    // Directed table: empty lines, short lines with extreme bytes, and
    // four-character lines whose empty payload leaves the CRC at its init.
    dir_table = '{
      plain(ChCr), plain(ChLf),
      plain(8'h00), word_row(ChCr, 1'b1, ST_SHORT, '0, '0, '0),
      plain(8'hFF), plain("Z"), word_row(ChLf, 1'b1, ST_SHORT, '0, '0, '0),
      plain(8'h80), plain("a"), plain("7"), word_row(ChCr, 1'b1, ST_SHORT, '0, '0, '0),
      plain("F"), plain("F"), plain("F"), plain("F"),
      word_row(ChCr, 1'b1, ST_MATCH, 16'hFFFF, 16'hFFFF, '0),
      plain("0"), plain("0"), plain("0"), plain("0"),
      word_row(ChLf, 1'b1, ST_MISMATCH, 16'hFFFF, 16'h0000, '0),
      plain("f"), plain("f"), plain("f"), plain("f"),
      word_row(ChCr, 1'b1, ST_MISMATCH, 16'hFFFF, 16'h0000, '0)
    };
    foreach (dir_table[i]) byte_words = {byte_words, dir_table[i]};

    // Over-long line that runs through the limit and is dropped, then a
    // fresh well-formed line with a three-byte payload.
    repeat (MaxLine + 1) push_word(text_byte());
    queue_line(KindGood, 3);

    // Random lines, mostly well-formed with random content.
    random_start = byte_words.size();
    while (byte_words.size() < random_start + RandomWords) begin
      case ($urandom_range(0, 49)) inside
        [0:29]:  queue_line(KindGood,
                            ($urandom_range(0, 39) == 0) ? $urandom_range(25, 120)
                                                         : $urandom_range(0, 24));
        [30:34]: queue_line(KindWrongCheck, $urandom_range(0, 24));
        [35:39]: queue_line(KindBadHex, $urandom_range(0, 24));
        [40:43]: queue_line(KindShort, 0);
        default: queue_line(KindNoise, 0);
      endcase
    end
    // Drop idling for the last part of the run.
    quiet_from = byte_words.size() * 85 / 100;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and every line result to arrive.
    while (byte_words.size() != 0 || in_tvalid) @(posedge clk);
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (line_results_q.size() != 0)
      report_mismatch("line results never arrived", 32'(line_results_q.size()), 32'h0);

    if (mismatch_count == 0) begin
      $display("crc_checked_line_deframer_core verification clean");
    end else begin
      $display("crc_checked_line_deframer_core verification failed");
    end
    $finish;
  end

endmodule
